// ===== rtl/kdpc_pkg.sv =====
package kdpc_pkg;

    // Event codes
    localparam logic [1:0] EV_PRESSED  = 2'd0;
    localparam logic [1:0] EV_RELEASED = 2'd1;
    localparam logic [1:0] EV_SHORT    = 2'd2;
    localparam logic [1:0] EV_LONG     = 2'd3;

    // Phase codes
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_DEBOUNCE = 2'd1;
    localparam logic [1:0] PH_STABLE   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PRESS_POLARITY  = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE_TIME   = 2'd1;
    localparam logic [1:0] CFG_LONG_PRESS_TIME = 2'd2;

    // Configuration reset values
    localparam logic        PRESS_POLARITY_RST  = 1'b0;
    localparam logic [15:0] DEBOUNCE_TIME_RST   = 16'd20;
    localparam logic [15:0] LONG_PRESS_TIME_RST = 16'd1000;

    // Result queue geometry
    localparam int RES_DEPTH   = 4;
    localparam int RES_PTR_W   = 2;
    localparam int RES_CNT_W   = 3;

    typedef struct packed {
        logic        pin_level;
        logic [31:0] now_tick;
    } in_item_t;

    typedef struct packed {
        logic [1:0] event_code;
        logic       last_in_run;
    } out_item_t;

    typedef struct packed {
        logic        press_polarity;
        logic [15:0] debounce_time;
        logic [15:0] long_press_time;
    } cfg_t;

    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } events_t;

endpackage

// ===== rtl/kdpc_core.sv =====
module kdpc_core #(
    parameter int TICK_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  kdpc_pkg::in_item_t item,
    input  kdpc_pkg::cfg_t    cfg,
    output kdpc_pkg::events_t ev
);

    logic [1:0]            phase_reg,        phase_next;
    logic                  settled_reg,      settled_next;
    logic [TICK_WIDTH-1:0] change_start_reg, change_start_next;
    logic [TICK_WIDTH-1:0] press_start_reg,  press_start_next;
    logic                  long_rep_reg,     long_rep_next;

    logic                  raw;
    logic [TICK_WIDTH-1:0] tick;
    logic [TICK_WIDTH-1:0] change_age;
    logic [TICK_WIDTH-1:0] press_age;
    logic                  debounce_done;
    logic                  long_done;

    assign raw           = cfg.press_polarity ? item.pin_level : ~item.pin_level;
    assign tick          = TICK_WIDTH'(item.now_tick);
    assign change_age    = tick - change_start_reg;
    assign press_age     = tick - press_start_reg;
    assign debounce_done = change_age >= TICK_WIDTH'(cfg.debounce_time);
    assign long_done     = press_age >= TICK_WIDTH'(cfg.long_press_time);

    always_comb
    begin
        phase_next        = phase_reg;
        settled_next      = settled_reg;
        change_start_next = change_start_reg;
        press_start_next  = press_start_reg;
        long_rep_next     = long_rep_reg;
        ev.count          = 2'd0;
        ev.first          = '{event_code: kdpc_pkg::EV_PRESSED, last_in_run: 1'b1};
        ev.second         = '{event_code: kdpc_pkg::EV_SHORT, last_in_run: 1'b1};
        if (advance)
        begin
            case (phase_reg)
                kdpc_pkg::PH_IDLE:
                begin
                    if (raw != settled_reg)
                    begin
                        phase_next        = kdpc_pkg::PH_DEBOUNCE;
                        change_start_next = tick;
                    end
                end
                kdpc_pkg::PH_DEBOUNCE:
                begin
                    if (raw != settled_reg)
                    begin
                        if (debounce_done)
                        begin
                            settled_next = raw;
                            phase_next   = kdpc_pkg::PH_STABLE;
                            if (raw)
                            begin
                                press_start_next = tick;
                                long_rep_next    = 1'b0;
                                ev.count         = 2'd1;
                                ev.first.event_code = kdpc_pkg::EV_PRESSED;
                            end
                            else if (!long_rep_reg)
                            begin
                                ev.count = 2'd2;
                                ev.first  = '{event_code: kdpc_pkg::EV_RELEASED,
                                              last_in_run: 1'b0};
                            end
                            else
                            begin
                                ev.count = 2'd1;
                                ev.first.event_code = kdpc_pkg::EV_RELEASED;
                            end
                        end
                    end
                    else
                    begin
                        // bounce back to the settled level
                        phase_next = settled_reg ? kdpc_pkg::PH_STABLE : kdpc_pkg::PH_IDLE;
                    end
                end
                kdpc_pkg::PH_STABLE:
                begin
                    if (raw != settled_reg)
                    begin
                        phase_next        = kdpc_pkg::PH_DEBOUNCE;
                        change_start_next = tick;
                    end
                    else if (raw && !long_rep_reg && long_done)
                    begin
                        long_rep_next       = 1'b1;
                        ev.count            = 2'd1;
                        ev.first.event_code = kdpc_pkg::EV_LONG;
                    end
                end
                default:
                begin
                    phase_next = kdpc_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= kdpc_pkg::PH_IDLE;
            settled_reg      <= 1'b0;
            change_start_reg <= '0;
            press_start_reg  <= '0;
            long_rep_reg     <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            settled_reg      <= settled_next;
            change_start_reg <= change_start_next;
            press_start_reg  <= press_start_next;
            long_rep_reg     <= long_rep_next;
        end
    end

endmodule

// ===== rtl/kdpc_res_fifo.sv =====
module kdpc_res_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  kdpc_pkg::events_t   ev,
    input  logic                pop,
    output logic                has_room,
    output logic                not_empty,
    output kdpc_pkg::out_item_t head
);

    kdpc_pkg::out_item_t                mem_reg [kdpc_pkg::RES_DEPTH];
    logic [kdpc_pkg::RES_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [kdpc_pkg::RES_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [kdpc_pkg::RES_CNT_W-1:0]     count_reg,  count_next;
    logic [kdpc_pkg::RES_PTR_W-1:0]     wr_ptr_b;

    assign wr_ptr_b  = wr_ptr_reg + 1'b1;
    assign has_room  = count_reg <= kdpc_pkg::RES_CNT_W'(kdpc_pkg::RES_DEPTH - 2);
    assign not_empty = count_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + kdpc_pkg::RES_PTR_W'(ev.count);
        rd_ptr_next = rd_ptr_reg + kdpc_pkg::RES_PTR_W'(pop);
        count_next  = count_reg + kdpc_pkg::RES_CNT_W'(ev.count)
                    - kdpc_pkg::RES_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (ev.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= ev.first;
        end
        if (ev.count == 2'd2)
        begin
            mem_reg[wr_ptr_b] <= ev.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/key_debounce_press_classifier_unit.sv =====
// Path: an accepted request waits in the input register until the result queue has
// room for two results, then steps the phase machine; its results go to the queue.
// Throughput: one request per cycle while each request yields at most one result
// and the output does not stall, as the four-entry result queue drains one result
// a cycle and so sets the rate. A release with a short press yields two results.
// Reset (rst_n, async, active low) clears the phase machine, the queue pointers
// and the configuration registers to their defaults; no clearing pass is needed.
module key_debounce_press_classifier_unit #(
    parameter int TICK_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    // input requests
    input  logic                in_valid,
    output logic                in_stall,
    input  kdpc_pkg::in_item_t  in_item,
    // result requests
    output logic                out_valid,
    input  logic                out_stall,
    output kdpc_pkg::out_item_t out_item,
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    // Input register: holds one accepted request until the queue can take
    // whatever it produces (up to two results).
    logic               s1_valid_reg, s1_valid_next;
    kdpc_pkg::in_item_t s1_item_reg;

    kdpc_pkg::cfg_t     cfg_reg, cfg_next;
    kdpc_pkg::events_t  ev;

    logic in_accept;
    logic advance;
    logic has_room;
    logic pop;

    // Config writes are always taken; an index past the list is dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                kdpc_pkg::CFG_PRESS_POLARITY:  cfg_next.press_polarity  = cfg_data[0];
                kdpc_pkg::CFG_DEBOUNCE_TIME:   cfg_next.debounce_time   = cfg_data;
                kdpc_pkg::CFG_LONG_PRESS_TIME: cfg_next.long_press_time = cfg_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_polarity  <= kdpc_pkg::PRESS_POLARITY_RST;
            cfg_reg.debounce_time   <= kdpc_pkg::DEBOUNCE_TIME_RST;
            cfg_reg.long_press_time <= kdpc_pkg::LONG_PRESS_TIME_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Advance the held request into the phase machine only when the queue has
    // space for the worst case; otherwise stall the input side.
    assign advance       = s1_valid_reg && has_room;
    assign in_stall      = s1_valid_reg && !has_room;
    assign in_accept     = in_valid && !in_stall;
    assign s1_valid_next = in_accept || (s1_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg <= in_item;
        end
    end

    kdpc_core #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_item_reg),
        .cfg     (cfg_reg),
        .ev      (ev)
    );

    // Drop one result from the queue head whenever the output side takes it.
    assign pop = out_valid && !out_stall;

    kdpc_res_fifo u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev        (ev),
        .pop       (pop),
        .has_room  (has_room),
        .not_empty (out_valid),
        .head      (out_item)
    );

`ifndef SYNTHESIS
    // Two results from one scan are always a release followed by a short press.
    a_pair_order : assert property (@(posedge clk) disable iff (!rst_n)
        ev.count == 2'd2 |-> ev.first.event_code == kdpc_pkg::EV_RELEASED &&
                             ev.second.event_code == kdpc_pkg::EV_SHORT &&
                             !ev.first.last_in_run && ev.second.last_in_run)
        else $error("result pair is not released then short");

    // A single result always closes its run.
    a_single_last : assert property (@(posedge clk) disable iff (!rst_n)
        ev.count == 2'd1 |-> ev.first.last_in_run)
        else $error("single result not marked last");

    // Results come only from a request that advances.
    a_no_invent : assert property (@(posedge clk) disable iff (!rst_n)
        !advance |-> ev.count == 2'd0)
        else $error("result produced without a request");

    // The input side stalls only while a request is held.
    a_stall_held : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && !has_room)
        else $error("input stalled with nothing held");
`endif

endmodule

// ===== tb/sv/key_debounce_press_classifier_unit_tb.sv =====
module key_debounce_press_classifier_unit_tb;

    // Register index past the end of the map; a write to it must be dropped.
    localparam logic [1:0] CFG_UNMAPPED = 2'd3;

    // Cycles to let pass after the last expected result before a register
    // write, to cover the input register and a full result queue.
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_REQUESTS  = 190;
    localparam int HOLD_OFF_AT     = 600;
    localparam int HOLD_OFF_CYCLES = 300;
    // Limit for the whole run, with a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT     = 400_000;

    // Press classifier tracker: mirrors the block's phase machine and
    // configuration, and holds the events still owed by the block.
    class press_scoreboard;
        logic        press_polarity;
        logic [15:0] debounce_time;
        logic [15:0] long_press_time;
        logic [1:0]  phase;
        logic        settled_level;
        logic [31:0] change_start;
        logic [31:0] press_start;
        logic        long_reported;
        kdpc_pkg::out_item_t expected_events[$];
        int          errors;

        function new();
            press_polarity  = kdpc_pkg::PRESS_POLARITY_RST;
            debounce_time   = kdpc_pkg::DEBOUNCE_TIME_RST;
            long_press_time = kdpc_pkg::LONG_PRESS_TIME_RST;
            phase           = kdpc_pkg::PH_IDLE;
            settled_level   = 1'b0;
            change_start    = '0;
            press_start     = '0;
            long_reported   = 1'b0;
            errors          = 0;
        endfunction

        function void note_config(logic [1:0] index, logic [15:0] value);
            case (index)
                kdpc_pkg::CFG_PRESS_POLARITY:  press_polarity  = value[0];
                kdpc_pkg::CFG_DEBOUNCE_TIME:   debounce_time   = value;
                kdpc_pkg::CFG_LONG_PRESS_TIME: long_press_time = value;
                default: ;
            endcase
        endfunction

        // Advance the phase machine by one scan and queue the events it fires.
        function void note_request(kdpc_pkg::in_item_t req);
            logic        pressed;
            logic [31:0] elapsed;
            logic [1:0]  fired[$];
            kdpc_pkg::out_item_t ev;
            pressed = press_polarity ? req.pin_level : ~req.pin_level;
            case (phase)
                kdpc_pkg::PH_IDLE:
                begin
                    if (pressed != settled_level)
                    begin
                        phase        = kdpc_pkg::PH_DEBOUNCE;
                        change_start = req.now_tick;
                    end
                end
                kdpc_pkg::PH_DEBOUNCE:
                begin
                    elapsed = req.now_tick - change_start;
                    if (pressed == settled_level)
                        phase = settled_level ? kdpc_pkg::PH_STABLE : kdpc_pkg::PH_IDLE;
                    else if (elapsed >= {16'd0, debounce_time})
                    begin
                        settled_level = pressed;
                        phase         = kdpc_pkg::PH_STABLE;
                        if (pressed)
                        begin
                            press_start   = req.now_tick;
                            long_reported = 1'b0;
                            fired.push_back(kdpc_pkg::EV_PRESSED);
                        end
                        else
                        begin
                            fired.push_back(kdpc_pkg::EV_RELEASED);
                            if (!long_reported)
                                fired.push_back(kdpc_pkg::EV_SHORT);
                        end
                    end
                end
                kdpc_pkg::PH_STABLE:
                begin
                    elapsed = req.now_tick - press_start;
                    if (pressed != settled_level)
                    begin
                        phase        = kdpc_pkg::PH_DEBOUNCE;
                        change_start = req.now_tick;
                    end
                    else if (pressed && !long_reported &&
                             elapsed >= {16'd0, long_press_time})
                    begin
                        long_reported = 1'b1;
                        fired.push_back(kdpc_pkg::EV_LONG);
                    end
                end
                default: phase = kdpc_pkg::PH_IDLE;
            endcase
            foreach (fired[i])
            begin
                ev.event_code  = fired[i];
                ev.last_in_run = (i == fired.size() - 1);
                expected_events.push_back(ev);
            end
        endfunction

        function void check_result(kdpc_pkg::out_item_t got);
            kdpc_pkg::out_item_t want;
            if (expected_events.size() == 0)
            begin
                $error("unexpected result: event_code %0d last_in_run %0d",
                       got.event_code, got.last_in_run);
                errors++;
                return;
            end
            want = expected_events.pop_front();
            if (got.event_code !== want.event_code)
            begin
                $error("event_code: expected %0d, actual %0d",
                       want.event_code, got.event_code);
                errors++;
            end
            if (got.last_in_run !== want.last_in_run)
            begin
                $error("last_in_run: expected %0d, actual %0d",
                       want.last_in_run, got.last_in_run);
                errors++;
            end
        endfunction

        function int pending();
            return expected_events.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    kdpc_pkg::in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    kdpc_pkg::out_item_t out_item;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    press_scoreboard sb;
    int requests_sent;
    int burst_left;
    bit hold_off_req;

    key_debounce_press_classifier_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Map a logical key level (1 = pressed) to the pin under the current polarity.
    function automatic logic pin_for(logic lvl);
        return sb.press_polarity ? lvl : ~lvl;
    endfunction

    // Offer one scan request and hold it until the block takes it. The sender
    // runs in bursts; between bursts drop valid for a random gap.
    task automatic scan_key(logic pin, logic [31:0] tick);
        kdpc_pkg::in_item_t req;
        int       gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        req.pin_level = pin;
        req.now_tick  = tick;
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (in_stall);
        sb.note_request(req);
        burst_left--;
        requests_sent++;
        // Ask the receiver for its long hold-off once, mid-run.
        if (requests_sent == HOLD_OFF_AT)
            hold_off_req = 1'b1;
    endtask

    // Stop offering, wait for every owed event, then let the pipeline go quiet.
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.note_config(index, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random key activity: mostly well-formed presses and releases with
    // bounces, held for random durations scaled to the debounce and
    // long-press times; about one step in ten is a single noise scan with a random pin
    // and often a wild tick jump.
    task automatic run_random_phase(int n_requests);
        int          goal;
        int          db;
        int          lp;
        int          bounces;
        int          kind;
        int          dur;
        int          hold;
        int          k;
        logic        lvl;
        logic        noise_pin;
        logic [31:0] tick;
        db   = int'(sb.debounce_time);
        lp   = int'(sb.long_press_time);
        goal = requests_sent + n_requests;
        lvl  = 1'($urandom_range(0, 1));
        // Start near the top of the tick range now and then to cross the wrap.
        if ($urandom_range(0, 3) == 0)
            tick = 32'hFFFF_FFFF - $urandom_range(0, 4 * (db + lp + 10));
        else
            tick = $urandom;
        while (requests_sent < goal)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 1))
                    tick = $urandom;
                else
                    tick += $urandom_range(0, db + lp + 1);
                noise_pin = 1'($urandom_range(0, 1));
                scan_key(noise_pin, tick);
            end
            else
            begin
                lvl = ~lvl;
                // Bounce: flip between the new and the old level a few times.
                bounces = $urandom_range(0, 3);
                for (k = 0; k < 2 * bounces && requests_sent < goal; k++)
                begin
                    tick += $urandom_range(0, db / 4 + 1);
                    scan_key(pin_for(lvl ^ k[0]), tick);
                end
                // Hold: too short to settle, settled but short, or past long press.
                kind = $urandom_range(0, 5);
                if (kind == 0)
                    dur = $urandom_range(0, db);
                else if (kind < 4)
                    dur = db + $urandom_range(0, lp);
                else
                    dur = db + lp + $urandom_range(1, lp + 50);
                hold = $urandom_range(1, 10);
                for (k = 0; k < hold && requests_sent < goal; k++)
                begin
                    tick += $urandom_range(0, 2 * dur / hold + 1);
                    scan_key(pin_for(lvl), tick);
                end
            end
        end
    endtask

    // Check every result the block hands over.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_item);
    end

    // Receiver: stall on a pattern of its own, switching between stretches
    // of no stall, light and heavy random stall and a fixed rhythm. Once the
    // sender asks, hold off for a long stretch so the result queue fills and
    // the block stalls its input.
    initial
    begin : receiver
        int  mode;
        int  stretch;
        int  beat;
        bit  hold_off_done;
        out_stall = 1'b0;
        hold_off_done = 1'b0;
        beat = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_req && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                repeat (HOLD_OFF_CYCLES)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(5, 60);
            repeat (stretch)
            begin
                @(negedge clk);
                beat++;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 99) < 30);
                    2: out_stall <= (beat % 4 == 3);
                    default: out_stall <= ($urandom_range(0, 99) < 70);
                endcase
            end
        end
    end

    // Watchdog: end the run if it has not finished within the limit.
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        logic        al;
        logic [15:0] db;
        logic [15:0] lp;
        sb            = new();
        requests_sent = 0;
        burst_left    = 0;
        hold_off_req  = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = kdpc_pkg::CFG_PRESS_POLARITY;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: pin low means pressed, debounce 20, long press 1000.
        scan_key(1'b1, 32'd0);            // released level at rest
        scan_key(1'b0, 32'd100);          // start debouncing a press
        scan_key(1'b0, 32'd110);          // not held long enough yet
        scan_key(1'b1, 32'd115);          // bounce back to idle
        scan_key(1'b0, 32'd200);
        scan_key(1'b0, 32'd220);          // press confirmed exactly at debounce
        scan_key(1'b0, 32'd1219);         // one tick short of long press
        scan_key(1'b0, 32'd1220);         // long press fires
        scan_key(1'b1, 32'd1300);
        scan_key(1'b0, 32'd1305);         // bounce back to stable while held
        scan_key(1'b1, 32'd1400);
        scan_key(1'b1, 32'd1420);         // release after long press: no short
        scan_key(1'b1, 32'hFFFF_FFFF);
        scan_key(1'b0, 32'hFFFF_FFF0);    // press across the tick wrap
        scan_key(1'b0, 32'h0000_0004);
        scan_key(1'b1, 32'h0000_0010);
        scan_key(1'b1, 32'h0000_0024);    // release with short press
        drain_block();

        // Active high, zero debounce and zero long-press times.
        write_register(kdpc_pkg::CFG_PRESS_POLARITY, 16'd1);
        write_register(kdpc_pkg::CFG_DEBOUNCE_TIME, 16'd0);
        write_register(kdpc_pkg::CFG_LONG_PRESS_TIME, 16'd0);
        write_register(CFG_UNMAPPED, 16'hFFFF);
        scan_key(1'b1, 32'd500);
        scan_key(1'b1, 32'd500);          // press on the first debouncing scan
        scan_key(1'b1, 32'd500);          // long press on the first held scan
        scan_key(1'b0, 32'd501);
        scan_key(1'b0, 32'd501);          // release only
        scan_key(1'b1, 32'd502);
        scan_key(1'b1, 32'd502);          // press
        scan_key(1'b0, 32'd503);
        scan_key(1'b0, 32'd503);          // release with short press

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_block();
            case (p)
                0:
                begin
                    al = 1'b0;
                    db = 16'($urandom_range(0, 40));
                    lp = 16'($urandom_range(0, 400));
                end
                1:
                begin
                    al = 1'b1;
                    db = 16'hFFFF;
                    lp = 16'hFFFF;
                end
                2:
                begin
                    al = 1'b0;
                    db = 16'd0;
                    lp = 16'hFFFF;
                end
                3:
                begin
                    al = 1'b1;
                    db = 16'hFFFF;
                    lp = 16'd0;
                end
                default:
                begin
                    al = 1'($urandom_range(0, 1));
                    db = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                     : 16'($urandom_range(0, 40));
                    lp = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                     : 16'($urandom_range(0, 400));
                end
            endcase
            write_register(kdpc_pkg::CFG_PRESS_POLARITY, {15'd0, al});
            write_register(kdpc_pkg::CFG_DEBOUNCE_TIME, db);
            write_register(kdpc_pkg::CFG_LONG_PRESS_TIME, lp);
            if (p % 3 == 0)
                write_register(CFG_UNMAPPED, 16'($urandom));
            run_random_phase(PHASE_REQUESTS);
        end
        drain_block();

        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
